// ===== rtl/core/arpc_pkg.sv =====
// Package for the address resolution cache: field types, table entry layout,
// action codes and controller states. No dependencies.

package arpc_pkg;

  typedef logic [31:0] ip_t;
  typedef logic [47:0] mac_t;
  typedef logic [3:0]  port_t;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_LEARN  = 2'd1,
    ACT_DELETE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic  valid;
    ip_t   ip;
    mac_t  mac;
    port_t port;
  } entry_t;

endpackage

// ===== rtl/core/arpc_if.sv =====
// Request and response channel interfaces of the address resolution cache.
// Depends on arpc_pkg for the field types.

interface arpc_req_if;
  logic            valid;
  logic            ready;
  logic [1:0]      action;
  arpc_pkg::ip_t   target_ip;
  arpc_pkg::mac_t  hw_address;
  arpc_pkg::port_t port_index;

  modport source (output valid, output action, output target_ip, output hw_address,
                  output port_index, input ready);
  modport sink (input valid, input action, input target_ip, input hw_address,
                input port_index, output ready);
endinterface

interface arpc_rsp_if;
  logic            valid;
  logic            ready;
  logic            hit;
  arpc_pkg::mac_t  found_mac;
  arpc_pkg::port_t found_port;
  logic            changed;
  logic            table_full;

  modport source (output valid, output hit, output found_mac, output found_port,
                  output changed, output table_full, input ready);
  modport sink (input valid, input hit, input found_mac, input found_port,
                input changed, input table_full, output ready);
endinterface

// ===== rtl/core/arpc_mem.sv =====
// Entry store of the address resolution cache: one write port and one read
// port with registered read data. Depends on arpc_pkg.

module arpc_mem #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr_i,
  output arpc_pkg::entry_t           rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr_i,
  input  arpc_pkg::entry_t           wr_data_i
);
  import arpc_pkg::*;

  entry_t mem_q [ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/arpc_ctrl.sv =====
// Controller of the address resolution cache: clearing pass, table scan,
// write-back and response register. Depends on arpc_pkg and arpc_if.

module arpc_ctrl #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  arpc_req_if.sink                   req,
  arpc_rsp_if.source                 rsp,
  output logic                       rd_en_o,
  output logic [$clog2(ENTRIES)-1:0] rd_addr_o,
  input  arpc_pkg::entry_t           rd_data_i,
  output logic                       wr_en_o,
  output logic [$clog2(ENTRIES)-1:0] wr_addr_o,
  output arpc_pkg::entry_t           wr_data_o
);
  import arpc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);
  localparam logic [CW-1:0] DEPTH = CW'(ENTRIES);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          chk_vld_q, chk_vld_d;
  logic [AW-1:0] chk_idx_q, chk_idx_d;

  logic [1:0]    act_q, act_d;
  ip_t           key_q, key_d;
  mac_t          mac_q, mac_d;
  port_t         port_q, port_d;

  logic          match_q, match_d;
  logic [AW-1:0] match_idx_q, match_idx_d;
  mac_t          match_mac_q, match_mac_d;
  port_t         match_port_q, match_port_d;
  logic          free_q, free_d;
  logic [AW-1:0] free_idx_q, free_idx_d;

  logic          out_vld_q, out_vld_d;
  logic          hit_q, hit_d;
  mac_t          fmac_q, fmac_d;
  port_t         fport_q, fport_d;
  logic          changed_q, changed_d;
  logic          full_q, full_d;

  logic          out_free;
  logic          out_load;
  logic          differs;

  assign out_free = !out_vld_q || rsp.ready;
  assign differs  = (match_mac_q != mac_q) || (match_port_q != port_q);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    act_d        = act_q;
    key_d        = key_q;
    mac_d        = mac_q;
    port_d       = port_q;
    match_d      = match_q;
    match_idx_d  = match_idx_q;
    match_mac_d  = match_mac_q;
    match_port_d = match_port_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    out_vld_d    = out_vld_q && !rsp.ready;
    hit_d        = hit_q;
    fmac_d       = fmac_q;
    fport_d      = fport_q;
    changed_d    = changed_q;
    full_d       = full_q;
    out_load     = 1'b0;
    req.ready    = 1'b0;
    rd_en_o      = 1'b0;
    rd_addr_o    = cnt_q[AW-1:0];
    wr_en_o      = 1'b0;
    wr_addr_o    = cnt_q[AW-1:0];
    wr_data_o    = '{valid: 1'b0, ip: key_q, mac: mac_q, port: port_q};

    case (state_q)
      ST_CLEAR: begin
        wr_en_o = 1'b1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          act_d   = req.action;
          key_d   = req.target_ip;
          mac_d   = req.hw_address;
          port_d  = req.port_index;
          match_d = 1'b0;
          free_d  = 1'b0;
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q < DEPTH) begin
          rd_en_o   = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = cnt_q[AW-1:0];
          cnt_d     = cnt_q + 1'b1;
        end
        if (chk_vld_q) begin
          if (rd_data_i.valid && rd_data_i.ip == key_q && !match_q) begin
            match_d      = 1'b1;
            match_idx_d  = chk_idx_q;
            match_mac_d  = rd_data_i.mac;
            match_port_d = rd_data_i.port;
          end
          if (!rd_data_i.valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
          if (cnt_q == DEPTH) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          hit_d     = 1'b0;
          fmac_d    = '0;
          fport_d   = '0;
          changed_d = 1'b0;
          full_d    = 1'b0;
          state_d   = ST_IDLE;
          case (act_q)
            ACT_LOOKUP: begin
              hit_d = match_q;
              if (match_q) begin
                fmac_d  = match_mac_q;
                fport_d = match_port_q;
              end
            end
            ACT_LEARN: begin
              hit_d = match_q;
              if (match_q) begin
                if (differs) begin
                  wr_en_o         = 1'b1;
                  wr_addr_o       = match_idx_q;
                  wr_data_o.valid = 1'b1;
                  changed_d       = 1'b1;
                end
              end else if (free_q) begin
                wr_en_o         = 1'b1;
                wr_addr_o       = free_idx_q;
                wr_data_o.valid = 1'b1;
                changed_d       = 1'b1;
              end else begin
                full_d = 1'b1;
              end
            end
            ACT_DELETE: begin
              hit_d = match_q;
              if (match_q) begin
                wr_en_o   = 1'b1;
                wr_addr_o = match_idx_q;
                changed_d = 1'b1;
              end
            end
            default: begin
              hit_d = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      chk_vld_q <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      match_q   <= match_d;
      free_q    <= free_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    act_q        <= act_d;
    key_q        <= key_d;
    mac_q        <= mac_d;
    port_q       <= port_d;
    match_idx_q  <= match_idx_d;
    match_mac_q  <= match_mac_d;
    match_port_q <= match_port_d;
    free_idx_q   <= free_idx_d;
    hit_q        <= hit_d;
    fmac_q       <= fmac_d;
    fport_q      <= fport_d;
    changed_q    <= changed_d;
    full_q       <= full_d;
  end

  assign rsp.valid      = out_vld_q;
  assign rsp.hit        = hit_q;
  assign rsp.found_mac  = fmac_q;
  assign rsp.found_port = fport_q;
  assign rsp.changed    = changed_q;
  assign rsp.table_full = full_q;

  a_wr_only_clear_or_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (state_q == ST_CLEAR || state_q == ST_FINISH))
    else $error("table written outside clearing pass or write-back");

  a_check_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> $past(rd_en_o))
    else $error("entry compared without a read in the previous cycle");

  a_changed_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && changed_d) |-> wr_en_o)
    else $error("change reported without a table write");

  a_full_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && full_d) |-> (!free_q && !match_q && !wr_en_o))
    else $error("full reported while a slot or match was available");

endmodule

// ===== rtl/core/arp_cache_table_top.sv =====
// Top level of the address resolution cache keyed by IPv4 address.
// Depends on arpc_pkg, arpc_if, arpc_mem and arpc_ctrl.
//
//   Channel  Dir  Payload                                          Accept
//   req_i    in   action, target_ip, hw_address, port_index        valid && ready
//   rsp_o    out  hit, found_mac, found_port, changed, table_full  valid && ready
//
// Each request is accepted in the idle state, then the table is scanned
// through its single read port, and then the write-back and the load of
// the response register follow in the finish state.
// After reset a clearing pass marks every slot free; no request is
// accepted until it ends.
// A new request is accepted while the previous response waits; write-back
// stalls only if the response register is still full at that point.

module arp_cache_table_top #(
  parameter int ENTRIES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  arpc_req_if.sink   req_i,
  arpc_rsp_if.source rsp_o
);
  import arpc_pkg::*;

  localparam int AW = $clog2(ENTRIES);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  arpc_mem #(
    .ENTRIES(ENTRIES)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  arpc_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req_i),
    .rsp      (rsp_o),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data)
  );

endmodule
